// ===== hdl/euler_to_quaternion_defines.svh =====
// Assertion macros for the Euler-to-quaternion block.
// Used by files that assert; expects clk and rst in scope.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

`ifndef SYNTH
`define E2Q_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2q check failed");
`define E2Q_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2q check failed");
`else
`define E2Q_ASSERT_IMP(label, ante, cons)
`define E2Q_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/e2q_pkg.sv =====
// Package for the Euler-to-quaternion block: constants, atan table, types.
// No dependencies.
package e2q_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int TRIG_STAGES     = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                   TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int SQRT_STAGES     = 32;
  localparam int QUO_BITS        = 20;
  // cordic + pair/triple/sum/square/sum-of-squares + sqrt + divider + output
  localparam int LATENCY         = TRIG_STAGES + 5 + SQRT_STAGES + QUO_BITS + 2;

  localparam logic signed [15:0] Q_ONE     = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN     = -16'sh8000;

  // Per-lane divider result handed back to the top level.
  typedef struct packed {
    logic [QUO_BITS-1:0] quo;
    logic                ovf;
    logic                neg;
    logic                zero;
  } div_res_t;

  // Arctangent of 2^-i in half-angle phase units (2^32 per turn), truncated.
  function automatic logic [31:0] atan_phase(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41721;
      15: v = 32'd20860;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2607;
      19: v = 32'd1303;
      20: v = 32'd651;
      21: v = 32'd325;
      22: v = 32'd162;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/e2q_angle_if.sv =====
// Input channel: one angle triple per transaction.
// No dependencies.
interface e2q_angle_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== hdl/e2q_quat_if.sv =====
// Output channel: one Q1.15 quaternion per transaction.
// No dependencies.
interface e2q_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== hdl/euler_to_quaternion.sv =====
// Euler angles (roll, pitch, yaw; 16-bit binary angle, 32768 = pi) to a
// normalized Q1.15 quaternion. Fully pipelined: one transaction accepted per
// clock while the output is not stalled, one result per transaction, with 16
// CORDIC steps (one CORDIC step per stage), 32 square-root stages and 20
// divider stages per component. A stall on the output freezes the whole
// pipeline, so ready on the input follows output ready whenever a result
// sits in the output register. Depends on e2q_pkg, e2q_cordic, e2q_div,
// the two channel interfaces and the assertion macro header.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion (
  input  logic              clk,
  input  logic              rst,
  e2q_angle_if.sink         angles,
  e2q_quat_if.source        quat
);

  localparam int LAT = e2q_pkg::LATENCY;
  localparam int NS  = e2q_pkg::SQRT_STAGES;

  logic en;
  logic vld [0:LAT-1];

  assign en           = !vld[LAT-1] || quat.ready;
  assign angles.ready = en;
  assign quat.valid   = vld[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= angles.valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // half-angle sine/cosine, three lanes
  logic signed [17:0] sr, cr, sp, cp, sy, cy;

  e2q_cordic u_roll  (.clk, .en, .angle(angles.roll_angle),  .sin_val(sr), .cos_val(cr));
  e2q_cordic u_pitch (.clk, .en, .angle(angles.pitch_angle), .sin_val(sp), .cos_val(cp));
  e2q_cordic u_yaw   (.clk, .en, .angle(angles.yaw_angle),   .sin_val(sy), .cos_val(cy));

  // pair products
  logic signed [35:0] cpcy, spcy, cpsy, spsy;
  logic signed [17:0] sr1, cr1;

  always_ff @(posedge clk) begin
    if (en) begin
      cpcy <= cp * cy;
      spcy <= sp * cy;
      cpsy <= cp * sy;
      spsy <= sp * sy;
      sr1  <= sr;
      cr1  <= cr;
    end
  end

  // triple products
  logic signed [53:0] x_a, x_b, y_a, y_b, z_a, z_b, w_a, w_b;

  always_ff @(posedge clk) begin
    if (en) begin
      x_a <= sr1 * cpcy;
      x_b <= cr1 * spsy;
      y_a <= cr1 * spcy;
      y_b <= sr1 * cpsy;
      z_a <= cr1 * cpsy;
      z_b <= sr1 * spcy;
      w_a <= cr1 * cpcy;
      w_b <= sr1 * spsy;
    end
  end

  // raw components, floor shift by 30; magnitude stays below 2^18
  logic signed [54:0] x_s, y_s, z_s, w_s;
  assign x_s = 55'(x_a) - 55'(x_b);
  assign y_s = 55'(y_a) + 55'(y_b);
  assign z_s = 55'(z_a) - 55'(z_b);
  assign w_s = 55'(w_a) + 55'(w_b);

  // component delay line: qd[0] is the raw component, qd[NS+2] meets the length
  logic signed [19:0] qd [0:NS+2][0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      qd[0][0] <= x_s[49:30];
      qd[0][1] <= y_s[49:30];
      qd[0][2] <= z_s[49:30];
      qd[0][3] <= w_s[49:30];
      for (int i = 1; i <= NS + 2; i++) qd[i] <= qd[i-1];
    end
  end

  // squares, then sum scaled by 2^20
  logic signed [39:0] sq [0:3];
  logic        [41:0] ss;
  logic        [62:0] sv   [0:NS];
  logic        [62:0] sres [0:NS];

  assign ss = 42'(sq[0]) + 42'(sq[1]) + 42'(sq[2]) + 42'(sq[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) sq[k] <= qd[0][k] * qd[0][k];
      sv[0]   <= {1'b0, ss, 20'b0};
      sres[0] <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 1; j <= NS; j++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * (j - 1));
    logic [62:0] trial;
    assign trial = sres[j-1] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[j-1] >= trial) begin
          sv[j]   <= sv[j-1] - trial;
          sres[j] <= (sres[j-1] >> 1) + BIT;
        end else begin
          sv[j]   <= sv[j-1];
          sres[j] <= sres[j-1] >> 1;
        end
      end
    end
  end

  // per-component divide by the length
  e2q_pkg::div_res_t dres [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_div
    e2q_div u_div (
      .clk,
      .en,
      .comp (qd[NS+2][k]),
      .len  (sres[NS][31:0]),
      .res  (dres[k])
    );
  end

  // round already folded in; sign and saturate into the output register
  function automatic logic signed [15:0] sat(input e2q_pkg::div_res_t d);
    logic signed [15:0] v;
    if (d.neg) begin
      if (d.ovf || d.quo > 20'd32768) v = e2q_pkg::Q_MIN;
      else                            v = 16'(20'd0 - d.quo);
    end else begin
      if (d.ovf || d.quo > 20'd32767) v = e2q_pkg::Q_ONE;
      else                            v = 16'(d.quo);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (dres[0].zero) begin
        // degenerate length: identity rotation
        quat.quat_x <= '0;
        quat.quat_y <= '0;
        quat.quat_z <= '0;
        quat.quat_w <= e2q_pkg::Q_ONE;
      end else begin
        quat.quat_x <= sat(dres[0]);
        quat.quat_y <= sat(dres[1]);
        quat.quat_z <= sat(dres[2]);
        quat.quat_w <= sat(dres[3]);
      end
    end
  end

  `E2Q_ASSERT_NXT(a_enter, angles.valid && angles.ready, vld[0])
  `E2Q_ASSERT_IMP(a_stall, quat.valid && !quat.ready, !angles.ready)
  `E2Q_ASSERT_NXT(a_drain, vld[LAT-2] && angles.ready, quat.valid)

endmodule

// ===== hdl/e2q_cordic.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of half a binary angle.
// Depends on e2q_pkg.
module e2q_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output logic signed [17:0] sin_val,
  output logic signed [17:0] cos_val
);

  localparam int N = e2q_pkg::TRIG_STAGES;

  logic signed [30:0] xs [0:N-1];
  logic signed [30:0] ys [0:N-1];
  logic signed [31:0] zs [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [30:0] px;
    logic signed [30:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] atn;

    if (i == 0) begin : g_first
      assign px = 31'sd268435456;
      assign py = '0;
      assign pz = {angle[15], angle, 15'b0};
    end else begin : g_rest
      assign px = xs[i-1];
      assign py = ys[i-1];
      assign pz = zs[i-1];
    end
    assign atn = $signed(e2q_pkg::atan_phase(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (pz >= 0) begin
          xs[i] <= px - (py >>> i);
          ys[i] <= py + (px >>> i);
          zs[i] <= pz - atn;
        end else begin
          xs[i] <= px + (py >>> i);
          ys[i] <= py - (px >>> i);
          zs[i] <= pz + atn;
        end
      end
    end
  end

  // scale G*2^15
  assign cos_val = xs[N-1][30:13];
  assign sin_val = ys[N-1][30:13];

endmodule

// ===== hdl/e2q_div.sv =====
// Pipelined restoring divider for one component: rounded q*2^25/m.
// Depends on e2q_pkg.
module e2q_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [19:0] comp,
  input  logic        [31:0] len,
  output e2q_pkg::div_res_t  res
);

  localparam int QB = e2q_pkg::QUO_BITS;

  logic [52:0]   rem  [0:QB];
  logic [32:0]   den  [0:QB];
  logic [QB-1:0] quo  [0:QB];
  logic          ovf  [0:QB];
  logic          neg  [0:QB];
  logic          zero [0:QB];

  logic [19:0] mag;
  logic [46:0] num;
  logic [32:0] dv;

  assign mag = comp[19] ? 20'(-comp) : 20'(comp);
  assign num = 47'({mag, 26'b0}) + 47'(len);
  assign dv  = {len, 1'b0};

  // setup: rounding offset, overflow precheck
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= 53'(num);
      den[0]  <= dv;
      quo[0]  <= '0;
      ovf[0]  <= 54'(num) >= {1'b0, dv, 20'b0};
      neg[0]  <= comp[19];
      zero[0] <= (len == '0);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [52:0] sub;
    assign sub = 53'(den[k]) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1]  <= den[k];
        ovf[k+1]  <= ovf[k];
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
        if (rem[k] >= sub) begin
          rem[k+1] <= rem[k] - sub;
          quo[k+1] <= quo[k] | (QB'(1) << SH);
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  assign res.quo  = quo[QB];
  assign res.ovf  = ovf[QB];
  assign res.neg  = neg[QB];
  assign res.zero = zero[QB];

endmodule
